### hdl/tboi_pkg.sv
// ----------------------------------------------------------------------------
// tboi_pkg: shared types and constants of the two-body orbit integrator
// Holds the channel payload structs, the shared unit request and response
// structs, the sequencer states and the saturation helpers.
// ----------------------------------------------------------------------------
package tboi_pkg;

  // Working widths of the shared arithmetic unit. The numerator register covers
  // the widest dividend for the default fraction-bit parameters.
  localparam int UNIT_W = 144;
  localparam int PROD_W = 128;
  localparam int CNT_W  = 8;

  localparam logic [15:0] STEP_RESET = 16'd1000;
  localparam logic [39:0] GRAV_RESET = 40'd132600000000;
  localparam logic [9:0]  MS_PER_S   = 10'd1000;

  // The drift divides by 1000 through a reciprocal multiply: ceil(2^68 / 1000)
  // gives the exact floor quotient for every dividend below 1000 * 2^48, and
  // anything at or above that bound saturates the 48-bit step anyway.
  localparam logic [63:0]       DRIFT_RECIP = 64'd295147905179352826;
  localparam int                DRIFT_SHIFT = 68;
  localparam int                DRIFT_LEN   = 59;
  localparam logic [PROD_W-1:0] DRIFT_LIMIT = PROD_W'(MS_PER_S) << 48;

  localparam logic MODE_LOAD = 1'b0;

  localparam logic REG_STEP_MS    = 1'b0;
  localparam logic REG_GRAV_PARAM = 1'b1;

  localparam logic [47:0] MAX48 = {1'b0, {47{1'b1}}};
  localparam logic [47:0] MIN48 = {1'b1, {47{1'b0}}};

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_ZERO_DIST  = 2'd2,
    ST_REJECTED   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_RT,
    S_DEN,
    S_GS,
    S_W,
    S_KM,
    S_KD,
    S_DM,
    S_DD,
    S_OUT
  } seq_state_e;

  typedef struct packed {
    logic              mode;
    logic signed [47:0] load_px;
    logic signed [47:0] load_py;
    logic signed [47:0] load_pz;
    logic signed [47:0] load_vx;
    logic signed [47:0] load_vy;
    logic signed [47:0] load_vz;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] out_px;
    logic signed [47:0] out_py;
    logic signed [47:0] out_pz;
    logic [47:0]        distance;
    status_e            status;
  } out_rsp_t;

  typedef struct packed {
    logic              start;
    unit_op_e          op;
    logic [CNT_W-1:0]  len;
    logic [UNIT_W-1:0] x;
    logic [PROD_W-1:0] y;
    logic [63:0]       b;
  } unit_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
    logic [47:0]       quo;
  } unit_rsp_t;

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? 48'(~v + 48'd1) : v;
  endfunction

  // Adds a magnitude with the given sign to a 48-bit value and clamps.
  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] d,
                                          input logic neg);
    logic [49:0] s;
    s = {{2{a[47]}}, a} + (neg ? 50'(~{2'b00, d} + 50'd1) : {2'b00, d});
    if (s[49:47] == 3'b000 || s[49:47] == 3'b111) begin
      return s[47:0];
    end
    return s[49] ? MIN48 : MAX48;
  endfunction

endpackage

### hdl/tboi_unit.sv
// ----------------------------------------------------------------------------
// tboi_unit: shared iterative arithmetic unit
// Shift-add multiplier, restoring divider with a saturating 48-bit quotient
// and a digit-by-digit square root, one step per cycle on one datapath.
// ----------------------------------------------------------------------------
module tboi_unit import tboi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  unit_op_e          op_q;
  logic [UNIT_W-1:0] x_q;
  logic [PROD_W-1:0] y_q, z_q;
  logic [63:0]       b_q;
  logic              sat_q;

  logic [PROD_W:0]   rem_sh;
  logic              div_ge;
  logic [PROD_W-1:0] sq_rem, sq_trial;
  logic              sq_ge;

  assign rem_sh   = {z_q, x_q[UNIT_W-1]};
  assign div_ge   = rem_sh >= {1'b0, y_q};
  assign sq_rem   = {z_q[PROD_W-3:0], x_q[UNIT_W-1 -: 2]};
  assign sq_trial = {{(PROD_W-50){1'b0}}, b_q[47:0], 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.len;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      op_q  <= req_i.op;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
      z_q   <= '0;
      b_q   <= (req_i.op == OP_MUL) ? req_i.b : '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (b_q[0]) z_q <= z_q + y_q;
          y_q <= y_q << 1;
          b_q <= b_q >> 1;
        end
        OP_DIV: begin
          z_q   <= div_ge ? PROD_W'(rem_sh - {1'b0, y_q}) : rem_sh[PROD_W-1:0];
          x_q   <= x_q << 1;
          b_q   <= {b_q[62:0], div_ge};
          sat_q <= sat_q | b_q[47];
        end
        OP_SQRT: begin
          z_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
          x_q <= x_q << 2;
          b_q <= {b_q[62:0], sq_ge};
        end
        default: ;
      endcase
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = z_q;
  assign rsp_o.quo  = (op_q == OP_DIV && sat_q) ? '1 : b_q[47:0];

endmodule

### hdl/two_body_orbit_integrator.sv
// ----------------------------------------------------------------------------
// two_body_orbit_integrator: fixed-point semi-implicit Euler orbit stepper
// Holds one body's position and velocity and advances it around a central
// mass on request, using one shared multiply/divide/square-root unit.
// ----------------------------------------------------------------------------
// Usage. A request on the input channel is either a load (mode 0), which sets
// position and velocity once, or a tick (mode 1), which computes the
// acceleration -GM*p/|p|^3, updates the velocity and then the position by one
// step of step_ms milliseconds. Every request gives exactly one response with
// the position, the distance |p| and a status code. A second load is rejected,
// a tick before the first load is flagged, and a tick at zero distance is
// flagged and leaves the state alone. Results saturate to 48 bits.
// The configuration channel is always ready; write it only while idle.
// Timing. All arithmetic runs through one bit-serial unit, one operation at a
// time: a load or a flagged tick runs three squares and a square root, and a
// full tick is dominated by four divisions. Input ready is high only while
// idle. A finished response waits in an output register; if the receiver
// stalls, the block holds there until the previous one is taken.
// Reset clears position, velocity and the loaded flag and restores the
// register defaults (step 1000 ms, GM 132600000000 km^3/s^2).
// ----------------------------------------------------------------------------
module two_body_orbit_integrator import tboi_pkg::*; #(
  parameter int POS_FRAC_BITS = 16,
  parameter int VEL_FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_rsp_t    out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [39:0] cfg_data_i
);

  seq_state_e        state_q, state_d;
  logic              pend_q, final_q, started_q, out_valid_q;
  logic [1:0]        ax_q;
  logic [15:0]       step_q;
  logic [39:0]       grav_q;
  logic [47:0]       pos_q [3];
  logic [47:0]       vel_q [3];

  logic [95:0]       r2_q;
  logic [47:0]       r_q, w_q, dist_q;
  logic [PROD_W-1:0] den_q, tmp_q;
  status_e           status_q;
  out_rsp_t          out_q;

  unit_req_t         unit_req;
  unit_rsp_t         unit_rsp;
  logic              in_acc, op_state, last_ax, out_load;
  logic [47:0]       pos_mag, vel_mag;
  logic [PROD_W-1:0] drift_num;
  logic [47:0]       drift_mag;

  tboi_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign last_ax     = (ax_q == 2'd2);
  assign pos_mag     = mag48(pos_q[ax_q]);
  assign vel_mag     = mag48(vel_q[ax_q]);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Drift dividend |v|*step scaled into raw position units per 1000 ms; the
  // divide by 1000 is a reciprocal multiply, saturating above the 48-bit range.
  assign drift_num = (tmp_q << POS_FRAC_BITS) >> VEL_FRAC_BITS;
  assign drift_mag = (drift_num >= DRIFT_LIMIT) ? '1 : unit_rsp.prod[DRIFT_SHIFT +: 48];

  // Sequencer: each arithmetic state issues one unit operation and moves on
  // when the unit reports it done; S_SQ stays until all three axes are squared.
  always_comb begin
    state_d       = state_q;
    op_state      = 1'b1;
    unit_req      = '0;
    unit_req.op   = OP_MUL;
    unit_req.len  = CNT_W'(48);
    unique case (state_q)
      S_IDLE: begin
        op_state = 1'b0;
        if (in_acc) state_d = S_SQ;
      end
      S_SQ: begin
        unit_req.y = PROD_W'(pos_mag);
        unit_req.b = 64'(pos_mag);
        if (unit_rsp.done && last_ax) state_d = S_RT;
      end
      S_RT: begin
        unit_req.op = OP_SQRT;
        unit_req.x  = {r2_q, 48'd0};
        if (unit_rsp.done) begin
          state_d = (final_q || unit_rsp.quo == '0) ? S_OUT : S_DEN;
        end
      end
      S_DEN: begin
        unit_req.y   = PROD_W'(r2_q);
        unit_req.b   = 64'(MS_PER_S);
        unit_req.len = CNT_W'(10);
        if (unit_rsp.done) state_d = S_GS;
      end
      S_GS: begin
        unit_req.y   = PROD_W'(grav_q);
        unit_req.b   = 64'(step_q);
        unit_req.len = CNT_W'(16);
        if (unit_rsp.done) state_d = S_W;
      end
      S_W: begin
        unit_req.op  = OP_DIV;
        unit_req.len = CNT_W'(UNIT_W);
        unit_req.x   = UNIT_W'(tmp_q[55:0]) << (2 * POS_FRAC_BITS + VEL_FRAC_BITS);
        unit_req.y   = den_q;
        if (unit_rsp.done) state_d = S_KM;
      end
      S_KM: begin
        unit_req.y = PROD_W'(w_q);
        unit_req.b = 64'(pos_mag);
        if (unit_rsp.done) state_d = S_KD;
      end
      S_KD: begin
        unit_req.op  = OP_DIV;
        unit_req.len = CNT_W'(UNIT_W);
        unit_req.x   = UNIT_W'(tmp_q);
        unit_req.y   = PROD_W'(r_q);
        if (unit_rsp.done) state_d = last_ax ? S_DM : S_KM;
      end
      S_DM: begin
        unit_req.y   = PROD_W'(vel_mag);
        unit_req.b   = 64'(step_q);
        unit_req.len = CNT_W'(16);
        if (unit_rsp.done) state_d = S_DD;
      end
      S_DD: begin
        unit_req.y   = drift_num;
        unit_req.b   = DRIFT_RECIP;
        unit_req.len = CNT_W'(DRIFT_LEN);
        if (unit_rsp.done) state_d = last_ax ? S_SQ : S_DM;
      end
      S_OUT: begin
        op_state = 1'b0;
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        op_state = 1'b0;
        state_d  = S_IDLE;
      end
    endcase
    unit_req.start = op_state && !pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      final_q     <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      ax_q        <= '0;
      step_q      <= STEP_RESET;
      grav_q      <= GRAV_RESET;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (unit_req.start) pend_q <= 1'b1;
      else if (unit_rsp.done) pend_q <= 1'b0;

      if (cfg_valid_i) begin
        if (cfg_index_i == REG_STEP_MS) step_q <= cfg_data_i[15:0];
        else if (cfg_index_i == REG_GRAV_PARAM) grav_q <= cfg_data_i;
      end

      if (in_acc) begin
        ax_q <= '0;
        if (in_req_i.mode == MODE_LOAD) begin
          final_q <= 1'b1;
          if (!started_q) begin
            started_q <= 1'b1;
            pos_q[0]  <= in_req_i.load_px;
            pos_q[1]  <= in_req_i.load_py;
            pos_q[2]  <= in_req_i.load_pz;
            vel_q[0]  <= in_req_i.load_vx;
            vel_q[1]  <= in_req_i.load_vy;
            vel_q[2]  <= in_req_i.load_vz;
          end
        end else begin
          final_q <= !started_q;
        end
      end

      if (unit_rsp.done) begin
        if (state_q == S_SQ || state_q == S_KD || state_q == S_DD) begin
          ax_q <= last_ax ? 2'd0 : ax_q + 2'd1;
        end
        if (state_q == S_KD) begin
          vel_q[ax_q] <= sat_add(vel_q[ax_q], unit_rsp.quo,
                                 !pos_q[ax_q][47] && pos_q[ax_q] != '0);
        end
        if (state_q == S_DD) begin
          pos_q[ax_q] <= sat_add(pos_q[ax_q], drift_mag, vel_q[ax_q][47]);
          if (last_ax) final_q <= 1'b1;
        end
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Working values of the current request; these need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      r2_q <= '0;
      if (in_req_i.mode == MODE_LOAD) status_q <= started_q ? ST_REJECTED : ST_OK;
      else status_q <= started_q ? ST_OK : ST_NOT_LOADED;
    end
    if (unit_rsp.done) begin
      unique case (state_q)
        S_SQ:  r2_q <= r2_q + unit_rsp.prod[95:0];
        S_RT: begin
          r_q    <= unit_rsp.quo;
          dist_q <= unit_rsp.quo;
          if (!final_q && unit_rsp.quo == '0) status_q <= ST_ZERO_DIST;
        end
        S_DEN: den_q <= unit_rsp.prod;
        S_W:   w_q   <= unit_rsp.quo;
        S_GS, S_KM, S_DM: tmp_q <= unit_rsp.prod;
        S_DD:  if (last_ax) r2_q <= '0;
        default: ;
      endcase
    end
    if (out_load) begin
      out_q.out_px   <= pos_q[0];
      out_q.out_py   <= pos_q[1];
      out_q.out_pz   <= pos_q[2];
      out_q.distance <= dist_q;
      out_q.status   <= status_q;
    end
  end

  // A request closes the input until its response has been produced.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again while a request was in progress");

  // The sequencer never starts the shared unit while it is still working.
  a_unit_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_req.start |-> !unit_rsp.busy)
    else $error("shared unit started while busy");

  // A zero-distance response reports a zero distance.
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_ZERO_DIST |-> out_rsp_o.distance == '0)
    else $error("zero-distance status with nonzero distance");

endmodule

### bench/tb_two_body_orbit_integrator.sv
// ----------------------------------------------------------------------------
// tb_two_body_orbit_integrator: self-checking bench for the orbit stepper
// Drives load and tick requests through the valid/ready input channel. A
// bit-exact fixed-point predictor of the orbit state gives the expected
// response for every accepted request. Responses are checked in order, field
// by field. Both sides idle at random, the receiver holds off once for a long
// stretch, and the step and GM registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_two_body_orbit_integrator;
  import tboi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam longint SPAN48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_MIN = -64'sh0000_8000_0000_0000;
  // One millisecond step moves the position by |v| / DRIFT_DIV raw units.
  localparam longint DRIFT_DIV = 64'd65536000;
  localparam logic [39:0] GM_TOP = 40'hFF_FFFF_FFFF;

  // Bit-exact model of the orbit state plus the queue of responses still owed.
  class orbit_scoreboard;
    logic [15:0] step_ms;
    logic [39:0] grav;
    longint      pos[3];
    longint      vel[3];
    bit          loaded;
    out_rsp_t    owed[$];
    int          errors;

    function new();
      step_ms = STEP_RESET;
      grav    = GRAV_RESET;
      loaded  = 1'b0;
      errors  = 0;
      foreach (pos[i]) begin
        pos[i] = 0;
        vel[i] = 0;
      end
    endfunction

    function logic [63:0] magnitude(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function longint clamp48(longint x);
      return (x > POS_MAX) ? POS_MAX : ((x < POS_MIN) ? POS_MIN : x);
    endfunction

    function longint cap48(logic [191:0] q);
      return (q > 192'(SPAN48)) ? SPAN48 : longint'(q[63:0]);
    endfunction

    function logic [127:0] radius_sq();
      logic [127:0] s;
      s = 0;
      foreach (pos[i]) s += 128'(magnitude(pos[i])) * 128'(magnitude(pos[i]));
      return s;
    endfunction

    function logic [63:0] floor_root(logic [127:0] s);
      logic [63:0] res;
      logic [63:0] c;
      res = 0;
      for (int b = 48; b >= 0; b--) begin
        c = res | (64'd1 << b);
        if (s >= 128'(c) * 128'(c)) res = c;
      end
      return res;
    endfunction

    // One semi-implicit Euler step: kick every axis, then drift on the new velocity.
    function status_e advance_orbit();
      logic [127:0] r2;
      logic [63:0]  r;
      logic [191:0] q;
      longint       w;
      longint       d;
      if (!loaded) return ST_NOT_LOADED;
      r2 = radius_sq();
      r  = floor_root(r2);
      if (r == 0) return ST_ZERO_DIST;
      q = ((192'(grav) * 192'(step_ms)) << 64) / (192'(r2) * 192'd1000);
      w = cap48(q);
      foreach (vel[i]) begin
        d = cap48((192'(w) * 192'(magnitude(pos[i]))) / 192'(r));
        vel[i] = clamp48(vel[i] + ((pos[i] > 0) ? -d : d));
      end
      foreach (pos[i]) begin
        q = ((192'(magnitude(vel[i])) * 192'(step_ms)) << 16) / (192'd1000 << 32);
        d = cap48(q);
        pos[i] = clamp48(pos[i] + ((vel[i] < 0) ? -d : d));
      end
      return ST_OK;
    endfunction

    function void note_request(in_req_t req);
      out_rsp_t exp_rsp;
      status_e  st;
      if (req.mode == MODE_LOAD) begin
        if (loaded) begin
          st = ST_REJECTED;
        end else begin
          pos[0] = longint'(req.load_px);
          pos[1] = longint'(req.load_py);
          pos[2] = longint'(req.load_pz);
          vel[0] = longint'(req.load_vx);
          vel[1] = longint'(req.load_vy);
          vel[2] = longint'(req.load_vz);
          loaded = 1'b1;
          st = ST_OK;
        end
      end else begin
        st = advance_orbit();
      end
      exp_rsp.out_px   = pos[0][47:0];
      exp_rsp.out_py   = pos[1][47:0];
      exp_rsp.out_pz   = pos[2][47:0];
      exp_rsp.distance = 48'(floor_root(radius_sq()));
      exp_rsp.status   = st;
      owed.push_back(exp_rsp);
    endfunction

    function void flag(string what, logic [47:0] want, logic [47:0] got);
      errors++;
      if (errors <= 10) $display("  mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_response(out_rsp_t got);
      out_rsp_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("  response with nothing outstanding: %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.out_px !== want.out_px) flag("out_px", want.out_px, got.out_px);
      if (got.out_py !== want.out_py) flag("out_py", want.out_py, got.out_py);
      if (got.out_pz !== want.out_pz) flag("out_pz", want.out_pz, got.out_pz);
      if (got.distance !== want.distance) flag("distance", want.distance, got.distance);
      if (got.status !== want.status) flag("status", 48'(want.status), 48'(got.status));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_req_t     in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_rsp_t    out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [39:0] cfg_data_i = '0;

  orbit_scoreboard sb;
  bit          gaps_on = 1'b1;
  int          hold_trig = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cycles = 0;

  two_body_orbit_integrator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The run fails once the cycle count passes the limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver side. A long hold-off is counted here; otherwise ready drops at
  // random while gaps are enabled.
  always @(negedge clk_i) begin
    if (hold_seen != hold_trig) begin
      hold_seen = hold_trig;
      hold_left = 5000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < 24);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic in_req_t tick_request();
    in_req_t      r;
    logic [319:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom};
    r = bits[$bits(in_req_t)-1:0];
    r.mode = ~MODE_LOAD;
    return r;
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is
  // never dropped between back-to-back requests; the next call either raises
  // a new payload or idles first.
  task automatic send_request(in_req_t req);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  // Drops the request line and waits until every owed response is in.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [39:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_STEP_MS) sb.step_ms = data[15:0];
    else sb.grav = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] step, logic [39:0] gm);
    drain();
    write_reg(REG_STEP_MS, 40'(step));
    write_reg(REG_GRAV_PARAM, gm);
  endtask

  // Steers the body, which moves on the x axis only, onto the origin: coast
  // with gravity off when heading inward, otherwise brake with a tuned GM and
  // a 1 ms step so that the body turns slowly inward without moving.
  task automatic steer_to_origin();
    logic [191:0] ap;
    logic [191:0] av;
    logic [191:0] s;
    logic [191:0] g;
    logic [191:0] lo;
    bit           inward;
    for (int n = 0; n < 40; n++) begin
      drain();
      if (sb.pos[0] == 0) break;
      ap = 192'(sb.magnitude(sb.pos[0]));
      av = 192'(sb.magnitude(sb.vel[0]));
      inward = (sb.pos[0] > 0) ? (sb.vel[0] < 0) : (sb.vel[0] > 0);
      if (inward) begin
        s = (ap * 192'(DRIFT_DIV) + av - 1) / av;
        set_config((s > 192'd65535) ? 16'd65535 : ((s == 0) ? 16'd1 : s[15:0]), 40'd0);
      end else begin
        lo = av + 1;
        g = (lo * 192'd1000 * ap * ap + (192'd1 << 64) - 1) >> 64;
        set_config(16'd1, (g > 192'(GM_TOP)) ? GM_TOP : ((g == 0) ? 40'd1 : g[39:0]));
      end
      send_request(tick_request());
    end
  endtask

  initial begin
    in_req_t     r;
    logic [47:0] f;
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A tick before any load is flagged.
    send_request(tick_request());
    // The single accepted load: 7000 km out on x, drifting outward.
    r = '0;
    r.mode    = MODE_LOAD;
    r.load_px = 48'sd458752000;
    r.load_vx = 48'sd1073741824;
    send_request(r);
    // Every later load is rejected, whatever its fields hold.
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: f = MAX48;
        1: f = MIN48;
        2: f = '1;
        3: f = '0;
        default: f = rand48();
      endcase
      r = {MODE_LOAD, f, f, f, f, f, f};
      send_request(r);
    end
    repeat (3) send_request(tick_request());
    // Zero step and zero GM both still run the tick with null terms.
    set_config(16'd0, GRAV_RESET);
    send_request(tick_request());
    set_config(16'd1, 40'd0);
    send_request(tick_request());
    set_config(16'd65535, GM_TOP);
    repeat (2) send_request(tick_request());
    set_config(16'd1, 40'd1);
    send_request(tick_request());
    set_config(STEP_RESET, GRAV_RESET);

    // Random part: nine phases, each with its own register setting.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(STEP_RESET, GRAV_RESET);
        3: set_config(16'd65535, 40'd1000000000000);
        6: set_config(16'd1, 40'd1);
        default: set_config(16'($urandom_range(1, 3000)), 40'({$urandom, $urandom}));
      endcase
      gaps_on = (ph != 4);
      if (ph == 2) hold_trig++;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(99) < 70) begin
          r = tick_request();
        end else begin
          r = {MODE_LOAD, rand48(), rand48(), rand48(), rand48(), rand48(), rand48()};
        end
        send_request(r);
      end
    end
    gaps_on = 1'b1;

    // Bring the body onto the origin and tick there: zero distance is flagged.
    steer_to_origin();
    drain();
    send_request(tick_request());
    send_request(tick_request());

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### two_body_orbit_integrator.f
hdl/tboi_pkg.sv
hdl/tboi_unit.sv
hdl/two_body_orbit_integrator.sv
bench/tb_two_body_orbit_integrator.sv
